// ===== hw/rtl/wst_pkg.sv =====
// Package: widths, register indexes and beat types for the window sum threshold counter.
package wst_pkg;

	localparam int MAX_WINDOW  = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(MAX_WINDOW);
	localparam int LEN_W       = 11;
	localparam int THR_W       = 16;
	localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
	localparam int TGT_W       = THR_W + LEN_W;
	localparam int TALLY_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_WINDOW_LENGTH     = cfg_idx_t'(0);
	localparam cfg_idx_t REG_AVERAGE_THRESHOLD = cfg_idx_t'(1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [THR_W-1:0]       thr_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [TGT_W-1:0]       tgt_t;
	typedef logic [TALLY_W-1:0]     tally_t;

	localparam tally_t TALLY_MAX = '1;

endpackage

// ===== hw/rtl/wst_if.sv =====
// Stream interfaces for sample beats in and result beats out.
interface wst_in_if;
	import wst_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last;
	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wst_out_if;
	import wst_pkg::*;
	logic   valid;
	logic   ready;
	logic   window_full;
	logic   window_meets;
	tally_t match_count;
	logic   last_out;
	modport source (output valid, output window_full, output window_meets,
		output match_count, output last_out, input ready);
	modport sink   (input valid, input window_full, input window_meets,
		input match_count, input last_out, output ready);
endinterface

// ===== hw/rtl/wst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read (read-old on collision).
module wst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/window_sum_threshold_counter.sv =====
// Top level: sliding window sum over a delay RAM, threshold compare and saturating tally.
//
//  channel   dir  handshake        payload
//  samples   in   valid/ready      sample[15:0], last
//  results   out  valid/ready      window_full, window_meets, match_count[31:0], last_out
//  cfg       in   cfg_we           cfg_index[1:0], cfg_wdata[15:0]
//
// One beat per cycle sustained while the results channel is ready; an accepted sample passes
// the delay RAM read, the sum update, and compare and tally into the output register.
// The running sum and the tally each close their loop in a single stage.
// arst_n clears pointers, counts, sum and tally; the delay RAM is not cleared.
// A stalled result holds the output register; earlier stages keep filling behind it.
module window_sum_threshold_counter (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  wst_pkg::cfg_idx_t       cfg_index,
	input  logic [wst_pkg::CFG_DATA_W-1:0] cfg_wdata,
	wst_in_if.sink                  samples,
	wst_out_if.source               results
);
	import wst_pkg::*;

	// configuration
	len_t length_q;
	thr_t thr_q;
	tgt_t target_q;
	len_t k_eff;
	logic cfg_clear;

	// stage 0 state
	addr_t wp_q;
	len_t  fill_q;
	logic  drop_old;
	len_t  fill_next;
	len_t  wp_ext;
	len_t  old_wide;
	addr_t wp_next;
	logic  accept;

	// pipeline
	logic    v_s1, drop_s1, full_s1, last_s1;
	sample_t sample_s1;
	sample_t old_data;
	logic    v_s2, full_s2, last_s2;
	sum_t    sum_s2;
	sum_t    sum_q;
	sum_t    sum_upd;
	tally_t  tally_q;
	tally_t  tally_next;
	logic    meets;

	logic   out_v_q, out_full_q, out_meets_q, out_last_q;
	tally_t out_count_q;

	logic out_free, s2_free, s1_free, take_s1, take_s2;

	assign cfg_clear = cfg_we &&
		(cfg_index == REG_WINDOW_LENGTH || cfg_index == REG_AVERAGE_THRESHOLD);

	always_comb begin
		priority if (length_q == '0) begin
			k_eff = len_t'(1);
		end else if (length_q > len_t'(MAX_WINDOW)) begin
			k_eff = len_t'(MAX_WINDOW);
		end else begin
			k_eff = length_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= len_t'(1);
			thr_q    <= '0;
			target_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH:     length_q <= cfg_wdata[LEN_W-1:0];
					REG_AVERAGE_THRESHOLD: thr_q    <= cfg_wdata[THR_W-1:0];
					default: ;
				endcase
			end
			target_q <= tgt_t'(thr_q) * tgt_t'(k_eff);
		end
	end

	// handshake chain
	assign out_free = !out_v_q || results.ready;
	assign take_s2  = v_s2 && out_free;
	assign s2_free  = !v_s2 || out_free;
	assign take_s1  = v_s1 && s2_free;
	assign s1_free  = !v_s1 || s2_free;
	assign samples.ready = s1_free;
	assign accept   = samples.valid && s1_free;

	// stage 0: pointer, fill count, RAM write of the new sample and read of the leaving one
	assign drop_old  = fill_q >= k_eff;
	assign fill_next = drop_old ? fill_q : fill_q + len_t'(1);
	assign wp_ext    = len_t'(wp_q);
	assign old_wide  = (wp_ext >= k_eff) ? wp_ext - k_eff
		: wp_ext + len_t'(MAX_WINDOW) - k_eff;
	assign wp_next   = (wp_q == addr_t'(MAX_WINDOW - 1)) ? '0 : wp_q + addr_t'(1);

	wst_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_delay (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (samples.sample),
		.re    (accept),
		.raddr (old_wide[ADDR_W-1:0]),
		.rdata (old_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cfg_clear || (accept && samples.last)) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wp_q   <= wp_next;
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample;
			drop_s1   <= drop_old;
			full_s1   <= fill_next >= k_eff;
			last_s1   <= samples.last;
		end
	end

	// stage 1: running sum
	assign sum_upd = sum_q - (drop_s1 ? sum_t'(old_data) : '0) + sum_t'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			if (cfg_clear || (take_s1 && last_s1)) begin
				sum_q <= '0;
			end else if (take_s1) begin
				sum_q <= sum_upd;
			end
			if (s2_free) begin
				v_s2 <= take_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			sum_s2  <= sum_upd;
			full_s2 <= full_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 2: compare and saturating tally
	assign meets      = full_s2 && (tgt_t'(sum_s2) >= target_q);
	assign tally_next = (meets && tally_q != TALLY_MAX) ? tally_q + tally_t'(1) : tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_clear || (take_s2 && last_s2)) begin
				tally_q <= '0;
			end else if (take_s2) begin
				tally_q <= tally_next;
			end
			if (out_free) begin
				out_v_q <= take_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			out_full_q  <= full_s2;
			out_meets_q <= meets;
			out_count_q <= tally_next;
			out_last_q  <= last_s2;
		end
	end

	assign results.valid        = out_v_q;
	assign results.window_full  = out_full_q;
	assign results.window_meets = out_meets_q;
	assign results.match_count  = out_count_q;
	assign results.last_out     = out_last_q;

	// fill count never runs past the window length
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_eff)
		else $error("fill count above window length");

	// a last beat leaving stage 2 restarts the tally
	a_tally_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take_s2 && last_s2 |=> tally_q == '0)
		else $error("tally not cleared after last beat");

	// the tally holds at its ceiling unless cleared
	a_tally_sat: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q == TALLY_MAX && !cfg_clear && !(take_s2 && last_s2) |=> tally_q == TALLY_MAX)
		else $error("tally wrapped");

	// a window that is not yet full never meets the threshold
	a_meets_full: assert property (@(posedge clk) disable iff (!arst_n)
		take_s2 && !full_s2 |=> !out_meets_q)
		else $error("meets flag without full window");

	// stage 1 only advances with RAM data from the beat it holds: no accept while it is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s2_free |-> !accept)
		else $error("beat accepted over a stalled stage");
endmodule
